// ===== rtl/core/rm2aa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rm2aa_pkg;

    localparam int unsigned  Q_ONE     = 16384;
    localparam int unsigned  ANGLE_MAX = 23040;
    localparam logic signed [25:0] DEG90_Z  = 26'sd5898240;
    localparam logic signed [25:0] DEG180_Z = 26'sd11796480;
    localparam int unsigned  TABLE_LEN = 24;
    localparam int unsigned  SQRT_BITS = 16;
    localparam int unsigned  QUOT_BITS = 15;

    // Payload carried down the pipeline; each section uses its own fields.
    typedef struct packed {
        logic signed [16:0] vx;
        logic signed [16:0] vy;
        logic signed [16:0] vz;
        logic signed [17:0] c2;
        logic [30:0]        sqx;
        logic [30:0]        sqy;
        logic [30:0]        sqz;
        logic [33:0]        rem;
        logic [15:0]        root;
        logic [30:0]        nx;
        logic [30:0]        ny;
        logic [30:0]        nz;
        logic [14:0]        qx;
        logic [14:0]        qy;
        logic [14:0]        qz;
        logic signed [19:0] cx;
        logic signed [19:0] cy;
        logic signed [25:0] cz;
    } pipe_t;

    // atan(2^-i) in units of 2^-16 degree
    function automatic logic signed [25:0] atan_lut(input logic [4:0] idx);
        logic signed [25:0] val;
        unique case (idx)
            5'd0:  val = 26'sd2949120;
            5'd1:  val = 26'sd1740967;
            5'd2:  val = 26'sd919879;
            5'd3:  val = 26'sd466945;
            5'd4:  val = 26'sd234379;
            5'd5:  val = 26'sd117304;
            5'd6:  val = 26'sd58666;
            5'd7:  val = 26'sd29335;
            5'd8:  val = 26'sd14668;
            5'd9:  val = 26'sd7334;
            5'd10: val = 26'sd3667;
            5'd11: val = 26'sd1833;
            5'd12: val = 26'sd917;
            5'd13: val = 26'sd458;
            5'd14: val = 26'sd229;
            5'd15: val = 26'sd115;
            5'd16: val = 26'sd57;
            5'd17: val = 26'sd29;
            5'd18: val = 26'sd14;
            5'd19: val = 26'sd7;
            5'd20: val = 26'sd4;
            5'd21: val = 26'sd2;
            5'd22: val = 26'sd1;
            default: val = 26'sd0;
        endcase
        return val;
    endfunction

    // Clamp a raw Q1.14 word to [-1.0, 1.0]
    function automatic logic signed [15:0] clamp_q14(input logic [15:0] raw);
        logic signed [15:0] v;
        v = signed'(raw);
        if (v > 16'sd16384) begin
            v = 16'sd16384;
        end else if (v < -16'sd16384) begin
            v = -16'sd16384;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rotation_matrix_to_axis_angle_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Every stage is a register slice with its own valid bit, followed by the output register.
// Throughput: one item per cycle while the sink does not stall the output register.
// The sequence is difference, square, sum, 16 root stages, 15 quotient stages, CORDIC steps.
// A stalled output holds; empty slices still fill, so bubbles close up under backpressure.
// Reset (aresetn low, synchronous) clears all valid bits; payload registers are not reset.
module rotation_matrix_to_axis_angle_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // row0_x, row0_y, row0_z, row1_x, row1_y, row1_z, row2_x, row2_y, row2_z
    input  wire logic [143:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // axis_x, axis_y, axis_z, angle_deg, one zero pad bit
    output logic [63:0]       m_tdata,
    // degenerate
    output logic [0:0]        m_tuser
);
    import rm2aa_pkg::*;

    localparam int S_SQ   = 1;
    localparam int S_SUM  = 2;
    localparam int SQ0    = 3;
    localparam int DV0    = SQ0 + SQRT_BITS;
    localparam int CD0    = DV0 + QUOT_BITS;
    localparam int NSTG   = CD0 + CORDIC_STEPS;

    pipe_t              pipe_reg  [NSTG];
    pipe_t              pipe_next [NSTG];
    logic [NSTG-1:0]    vld_reg;
    logic [NSTG-1:0]    en;
    logic               m_tvalid_reg;
    logic [63:0]        m_tdata_reg;
    logic               m_tuser_reg;
    logic               out_en;

    // A slice takes new data when it is empty or its content moves on
    assign out_en   = !m_tvalid_reg || m_tready;
    always_comb begin
        en = '0;
        en[NSTG-1] = !vld_reg[NSTG-1] || out_en;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end
    assign s_tready = en[0];

    // Difference vector and trace term
    always_comb begin
        logic signed [15:0] a [9];
        pipe_t p;
        for (int k = 0; k < 9; k++) begin
            a[k] = clamp_q14(s_tdata[16*k +: 16]);
        end
        p    = '0;
        p.vx = 17'(a[5]) - 17'(a[7]);
        p.vy = 17'(a[6]) - 17'(a[2]);
        p.vz = 17'(a[1]) - 17'(a[3]);
        p.c2 = 18'(a[0]) + 18'(a[4]) + 18'(a[8]) - 18'sd16384;
        pipe_next[0] = p;
    end

    // Squares
    always_comb begin
        logic signed [33:0] px, py, pz;
        pipe_t p;
        p  = pipe_reg[S_SQ-1];
        px = p.vx * p.vx;
        py = p.vy * p.vy;
        pz = p.vz * p.vz;
        p.sqx = px[30:0];
        p.sqy = py[30:0];
        p.sqz = pz[30:0];
        pipe_next[S_SQ] = p;
    end

    // Sum of squares
    always_comb begin
        pipe_t p;
        p      = pipe_reg[S_SUM-1];
        p.rem  = 34'(p.sqx) + 34'(p.sqy) + 34'(p.sqz);
        p.root = '0;
        pipe_next[S_SUM] = p;
    end

    // Square root, one result bit a stage, most significant first
    for (genvar g = 0; g < SQRT_BITS; g++) begin : g_sqrt
        localparam int B = SQRT_BITS - 1 - g;
        always_comb begin
            logic [33:0] t;
            pipe_t p;
            p = pipe_reg[SQ0+g-1];
            t = (34'(p.root) << (B + 1)) + (34'd1 << (2 * B));
            if (p.rem >= t) begin
                p.rem       = p.rem - t;
                p.root[B]   = 1'b1;
            end
            pipe_next[SQ0+g] = p;
        end
    end

    // Three restoring dividers for |v| * 2^14 / L, one quotient bit a stage
    for (genvar g = 0; g < QUOT_BITS; g++) begin : g_div
        localparam int B = QUOT_BITS - 1 - g;
        always_comb begin
            logic [30:0] d;
            logic [15:0] mx, my, mz;
            pipe_t p;
            p  = pipe_reg[DV0+g-1];
            mx = p.vx[16] ? 16'(-p.vx) : 16'(p.vx);
            my = p.vy[16] ? 16'(-p.vy) : 16'(p.vy);
            mz = p.vz[16] ? 16'(-p.vz) : 16'(p.vz);
            if (g == 0) begin
                p.nx = (31'(mx) << 14) + 31'(p.root >> 1);
                p.ny = (31'(my) << 14) + 31'(p.root >> 1);
                p.nz = (31'(mz) << 14) + 31'(p.root >> 1);
                p.qx = '0;
                p.qy = '0;
                p.qz = '0;
            end
            d = 31'(p.root) << B;
            if (p.nx >= d) begin
                p.nx    = p.nx - d;
                p.qx[B] = 1'b1;
            end
            if (p.ny >= d) begin
                p.ny    = p.ny - d;
                p.qy[B] = 1'b1;
            end
            if (p.nz >= d) begin
                p.nz    = p.nz - d;
                p.qz[B] = 1'b1;
            end
            pipe_next[DV0+g] = p;
        end
    end

    // Vectoring CORDIC, one micro-rotation a stage
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        always_comb begin
            logic signed [19:0] dx, dy;
            logic signed [25:0] ang;
            pipe_t p;
            p = pipe_reg[CD0+g-1];
            if (g == 0) begin
                if (p.c2 < 0) begin
                    p.cx = 20'(signed'({1'b0, p.root}));
                    p.cy = -20'(p.c2);
                    p.cz = DEG90_Z;
                end else begin
                    p.cx = 20'(p.c2);
                    p.cy = 20'(signed'({1'b0, p.root}));
                    p.cz = '0;
                end
            end
            dx  = p.cy >>> g;
            dy  = p.cx >>> g;
            ang = atan_lut(5'(g));
            if (!p.cy[19]) begin
                p.cx = p.cx + dx;
                p.cy = p.cy - dy;
                p.cz = p.cz + ang;
            end else begin
                p.cx = p.cx - dx;
                p.cy = p.cy + dy;
                p.cz = p.cz - ang;
            end
            pipe_next[CD0+g] = p;
        end
    end

    // Slice registers
    for (genvar g = 0; g < NSTG; g++) begin : g_slice
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en[g]) begin
                vld_reg[g] <= (g == 0) ? s_tvalid : vld_reg[(g == 0) ? 0 : g-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (en[g]) begin
                pipe_reg[g] <= pipe_next[g];
            end
        end
    end

    // Result formatting: clamp angle, round, apply signs, handle the zero vector
    logic [63:0] res_data;
    logic        res_degen;
    always_comb begin
        logic signed [25:0] z;
        logic [25:0]        zr;
        logic [14:0]        ang;
        logic [14:0]        q [3];
        logic               neg [3];
        logic [15:0]        ax [3];
        pipe_t p;
        p      = pipe_reg[NSTG-1];
        z      = p.cz;
        if (z < 0) begin
            z = '0;
        end else if (z > DEG180_Z) begin
            z = DEG180_Z;
        end
        zr  = unsigned'(z) + 26'd256;
        ang = zr[23:9];
        if (ang > 15'(ANGLE_MAX)) begin
            ang = 15'(ANGLE_MAX);
        end
        q[0]   = p.qx;
        q[1]   = p.qy;
        q[2]   = p.qz;
        neg[0] = p.vx[16];
        neg[1] = p.vy[16];
        neg[2] = p.vz[16];
        res_degen = (p.root == '0);
        for (int k = 0; k < 3; k++) begin
            if (q[k] > 15'(Q_ONE)) begin
                q[k] = 15'(Q_ONE);
            end
            ax[k] = neg[k] ? -16'(q[k]) : 16'(q[k]);
            if (res_degen) begin
                ax[k] = '0;
            end
        end
        if (res_degen) begin
            ang = (p.c2 < 0) ? 15'(ANGLE_MAX) : 15'd0;
        end
        res_data = {1'b0, ang, ax[2], ax[1], ax[0]};
    end

    // Output register: hold while the sink stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_en) begin
            m_tvalid_reg <= vld_reg[NSTG-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (out_en) begin
            m_tdata_reg <= res_data;
            m_tuser_reg <= res_degen;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

`ifndef SYNTHESIS
    a_degen_axis_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[47:0] == 48'd0)
        else $error("degenerate item with nonzero axis");
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[62:48] <= 15'd23040)
        else $error("angle beyond 180 degrees");
    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output can move");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // Conversion pipeline depth at the default step count; used for the drain check.
    localparam int PIPE_DEPTH = 51;
    localparam int STEPS = 16;
    localparam int RANDOM_ITEMS = 900;
    localparam int IDLE_LIMIT = 20000;

    localparam logic signed [15:0] ONE  = 16'sd16384;
    localparam logic signed [15:0] MONE = -16'sd16384;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [14:0]        angle;
        logic               degen;
    } pose_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;

    pose_t expected_poses[$];
    int    error_count;
    int    quiet_cycles;
    bit    stimulus_done;
    bit    hold_off_active;
    bit    no_idle;

    rotation_matrix_to_axis_angle_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // atan(2^-i) in 2^-16 degree
    function automatic longint arctan_step(input int i);
        longint t[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
        return t[i];
    endfunction

    function automatic longint clamp_entry(input logic [15:0] raw);
        longint v;
        v = longint'($signed(raw));
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return v;
    endfunction

    function automatic longint isqrt(input longint n);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= n) begin
            r = r + 1;
            if (r * r * 4 < n) r = r * 2 - 1;
        end
        return r;
    endfunction

    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic logic signed [15:0] normalize(input longint vk, input longint len);
        longint mag, q;
        mag = vk < 0 ? -vk : vk;
        q = (mag * 16384 + len / 2) / len;
        if (q > 16384) q = 16384;
        return vk < 0 ? 16'(-q) : 16'(q);
    endfunction

    // Predict the axis-angle form of one frame.
    function automatic pose_t frame_to_pose(input logic [143:0] frame);
        longint e[9];
        longint vx, vy, vz, c2, len, x, y, z, dx, dy, ang;
        pose_t  p;
        for (int k = 0; k < 9; k++) e[k] = clamp_entry(frame[16*k +: 16]);
        vx = e[5] - e[7];
        vy = e[6] - e[2];
        vz = e[1] - e[3];
        c2 = e[0] + e[4] + e[8] - 16384;
        len = isqrt(vx * vx + vy * vy + vz * vz);
        p = '0;
        if (len == 0) begin
            p.degen = 1'b1;
            p.angle = c2 < 0 ? 15'd23040 : 15'd0;
        end else begin
            if (c2 < 0) begin
                x = len; y = -c2; z = 5898240;
            end else begin
                x = c2; y = len; z = 0;
            end
            for (int i = 0; i < STEPS; i++) begin
                dx = floor_shr(y, i);
                dy = floor_shr(x, i);
                if (y >= 0) begin
                    x += dx; y -= dy; z += arctan_step(i);
                end else begin
                    x -= dx; y += dy; z -= arctan_step(i);
                end
            end
            if (z < 0) z = 0;
            if (z > 11796480) z = 11796480;
            ang = (z + 256) / 512;
            if (ang > 23040) ang = 23040;
            p.angle = ang[14:0];
            p.ax = normalize(vx, len);
            p.ay = normalize(vy, len);
            p.az = normalize(vz, len);
        end
        return p;
    endfunction

    function automatic logic [143:0] pack_frame(input logic signed [15:0] m[9]);
        logic [143:0] f;
        for (int k = 0; k < 9; k++) f[16*k +: 16] = m[k];
        return f;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d want %0d", what, got, want);
        error_count++;
    endtask

    // Offer one frame and hold it until it is taken; queue its pose.
    task automatic send_frame(input logic [143:0] frame, input bit typed_in,
                              input pose_t typed_pose);
        pose_t want;
        // drop valid only while idling, so back-to-back frames keep it high
        while (!no_idle && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        want = frame_to_pose(frame);
        if (typed_in && want != typed_pose) begin
            report_mismatch("directed table vs predictor", want, typed_pose);
        end
        expected_poses = {expected_poses, want};
        s_tvalid <= 1'b1;
        s_tdata  <= frame;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Random frame: near-orthonormal rotation, raw noise, or extremes.
    function automatic logic [143:0] random_frame();
        logic signed [15:0] m[9];
        real th, c, s;
        int kind, a;
        kind = $urandom_range(9);
        if (kind < 6) begin
            th = ($urandom_range(36000) / 100.0 - 180.0) * 3.14159265358979 / 180.0;
            c = $cos(th);
            s = $sin(th);
            a = $urandom_range(2);
            for (int k = 0; k < 9; k++) m[k] = '0;
            m[a*4] = 16'sd16384;
            m[((a+1)%3)*4] = 16'($rtoi(c * 16384.0));
            m[((a+2)%3)*4] = 16'($rtoi(c * 16384.0));
            m[((a+1)%3)*3 + (a+2)%3] = 16'($rtoi(s * 16384.0));
            m[((a+2)%3)*3 + (a+1)%3] = 16'(-$rtoi(s * 16384.0));
            for (int k = 0; k < 9; k++)
                m[k] = 16'(m[k] + $signed(16'($urandom_range(40))) - 20);
        end else if (kind < 8) begin
            for (int k = 0; k < 9; k++)
                m[k] = 16'($signed(17'($urandom_range(32768))) - 16384);
        end else begin
            for (int k = 0; k < 9; k++) m[k] = 16'($urandom);
        end
        return pack_frame(m);
    endfunction

    // Sender
    initial begin
        logic signed [15:0] ident[9] = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
        logic signed [15:0] flip_x[9] = '{ONE, 0, 0, 0, MONE, 0, 0, 0, MONE};
        logic signed [15:0] over[9] = '{16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 16'sh7FFF};
        logic signed [15:0] under[9] = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};
        logic signed [15:0] rot_z90[9] = '{0, ONE, 0, MONE, 0, 0, 0, 0, ONE};
        logic signed [15:0] skew_max[9] = '{0, ONE, MONE, MONE, 0, ONE, ONE, MONE, 0};
        logic signed [15:0] zeros[9] = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        logic signed [15:0] allneg[9] = '{MONE, MONE, MONE, MONE, MONE, MONE, MONE,
                                          MONE, MONE};
        logic signed [15:0] allpos[9] = '{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE};
        logic signed [15:0] ones_bits[9] = '{16'shFFFF, 16'sh5555, 16'shAAAA, 16'sh0001,
                                             16'sh4000, 16'shC000, 16'sh3FFF, 16'shBFFF,
                                             16'sh7FFE};
        logic [143:0] rows[10];
        bit           typed[10];
        pose_t        poses[10];
        s_tvalid = 1'b0;
        s_tdata  = '0;
        aresetn  = 1'b0;
        stimulus_done = 1'b0;
        no_idle = 1'b0;
        rows = '{pack_frame(ident), pack_frame(flip_x), pack_frame(over), pack_frame(under),
                 pack_frame(rot_z90), pack_frame(skew_max), pack_frame(zeros),
                 pack_frame(allneg), pack_frame(allpos), pack_frame(ones_bits)};
        // degenerate; identity, over: 0; half-turn, under, zeros, all-minus: 180 degrees
        typed = '{1, 1, 1, 1, 0, 0, 1, 1, 0, 0};
        poses[0] = '{16'sd0, 16'sd0, 16'sd0, 15'd0, 1'b1};
        poses[1] = '{16'sd0, 16'sd0, 16'sd0, 15'd23040, 1'b1};
        poses[2] = '{16'sd0, 16'sd0, 16'sd0, 15'd0, 1'b1};
        poses[3] = '{16'sd0, 16'sd0, 16'sd0, 15'd23040, 1'b1};
        poses[6] = '{16'sd0, 16'sd0, 16'sd0, 15'd23040, 1'b1};
        poses[7] = '{16'sd0, 16'sd0, 16'sd0, 15'd23040, 1'b1};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int r = 0; r < 10; r++) send_frame(rows[r], typed[r], poses[r]);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 300 && n < 450);
            send_frame(random_frame(), 1'b0, poses[0]);
        end
        s_tvalid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Receiver: random stalls, one long hold-off while the sender keeps offering.
    initial begin
        int accepted;
        accepted = 0;
        m_tready = 1'b0;
        hold_off_active = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) accepted++;
            if (accepted == 150 && !hold_off_active) begin
                hold_off_active = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 36);
            end
        end
    end

    // Checker and watchdog
    initial begin
        pose_t want;
        pose_t got;
        error_count = 0;
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (aresetn && m_tvalid && m_tready) begin
                got.ax    = m_tdata[15:0];
                got.ay    = m_tdata[31:16];
                got.az    = m_tdata[47:32];
                got.angle = m_tdata[62:48];
                got.degen = m_tuser[0];
                if (expected_poses.size() == 0) begin
                    report_mismatch("unexpected item", m_tdata[62:48], -1);
                end else begin
                    want = expected_poses.pop_front();
                    if (got.ax != want.ax) report_mismatch("axis_x", got.ax, want.ax);
                    if (got.ay != want.ay) report_mismatch("axis_y", got.ay, want.ay);
                    if (got.az != want.az) report_mismatch("axis_z", got.az, want.az);
                    if (got.angle != want.angle)
                        report_mismatch("angle_deg", got.angle, want.angle);
                    if (got.degen != want.degen)
                        report_mismatch("degenerate", got.degen, want.degen);
                end
            end
            if (stimulus_done && expected_poses.size() == 0 && quiet_cycles > 4 * PIPE_DEPTH)
            begin
                if (error_count == 0) $display("rotation_matrix_to_axis_angle_unit verification clean");
                else $display("rotation_matrix_to_axis_angle_unit verification failed");
                $finish;
            end
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("rotation_matrix_to_axis_angle_unit verification failed");
                $finish;
            end
        end
    end

endmodule
